// File: rtl/whf_pkg.sv
package whf_pkg;

  localparam int unsigned NBINS  = 256;
  localparam int unsigned SLOTS  = NBINS + 2;
  localparam int unsigned SLOT_W = 9;
  localparam int unsigned ADDR_W = $clog2(SLOTS);
  localparam int unsigned XW     = 32;
  localparam int unsigned WGT_W  = 16;
  localparam int unsigned WSQ_W  = 31;
  localparam int unsigned WT_W   = 48;
  localparam int unsigned SQ_W   = 63;
  localparam int unsigned ENT_W  = 32;
  localparam int unsigned CFG_W  = 32;
  localparam int unsigned CIDX_W = 2;
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic {
    FUNC_FILL = 1'b0,
    FUNC_READ = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    CLS_BIN   = 2'd0,
    CLS_UNDER = 2'd1,
    CLS_OVER  = 2'd2
  } cls_e;

  typedef enum logic [CIDX_W-1:0] {
    CFG_X_MIN     = 2'd0,
    CFG_X_MAX     = 2'd1,
    CFG_BIN_SCALE = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_EXEC = 1'b1
  } bk_state_e;

  typedef struct packed {
    logic signed [XW-1:0] x_min;
    logic signed [XW-1:0] x_max;
    logic [XW-1:0]        bin_scale;
  } cfg_t;

  typedef struct packed {
    func_e                   func;
    logic [SLOT_W-1:0]       slot;
    logic                    in_range;
    logic signed [WGT_W-1:0] weight;
    logic [WSQ_W-1:0]        wsq;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef struct packed {
    logic signed [WT_W-1:0] wsum;
    logic [SQ_W-1:0]        ssum;
  } slot_t;

endpackage

// File: rtl/whf_if.sv
interface whf_in_if;
  logic                              valid;
  logic                              ready;
  logic                              func;
  logic signed [whf_pkg::XW-1:0]     sample;
  logic signed [whf_pkg::WGT_W-1:0]  weight;
  logic [whf_pkg::SLOT_W-1:0]        read_slot;

  modport source (output valid, func, sample, weight, read_slot, input ready);
  modport sink (input valid, func, sample, weight, read_slot, output ready);
endinterface

interface whf_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [whf_pkg::WT_W-1:0]  weight_total;
  logic [whf_pkg::SQ_W-1:0]         square_total;
  logic [whf_pkg::ENT_W-1:0]        entry_total;

  modport source (output valid, weight_total, square_total, entry_total, input ready);
  modport sink (input valid, weight_total, square_total, entry_total, output ready);
endinterface

// File: rtl/whf_front.sv
module whf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  whf_pkg::cfg_t     cfg_i,
  whf_in_if.sink            req_i,
  output logic              push_o,
  output whf_pkg::cmd_t     cmd_o,
  input  logic              q_ready_i
);

  logic                             s1_v_q, s1_v_d;
  whf_pkg::func_e                   s1_func_q;
  whf_pkg::cls_e                    s1_cls_q, cls_d;
  logic [whf_pkg::XW-1:0]           s1_diff_q;
  logic signed [whf_pkg::WGT_W-1:0] s1_wgt_q;
  logic [whf_pkg::SLOT_W-1:0]       s1_rs_q;

  logic                             s2_v_q, s2_v_d;
  whf_pkg::func_e                   s2_func_q;
  whf_pkg::cls_e                    s2_cls_q;
  logic [2*whf_pkg::XW-1:0]         s2_prod_q;
  logic signed [whf_pkg::WGT_W-1:0] s2_wgt_q;
  logic [whf_pkg::WSQ_W-1:0]        s2_wsq_q;
  logic [whf_pkg::SLOT_W-1:0]       s2_rs_q;

  logic                             s1_rdy, s2_go;
  logic signed [2*whf_pkg::WGT_W-1:0] wsq_full;
  logic [2*whf_pkg::XW-24-1:0]      idx;

  assign s2_go   = !s2_v_q || q_ready_i;
  assign s1_rdy  = !s1_v_q || s2_go;
  assign req_i.ready = s1_rdy;

  always_comb begin
    if (req_i.sample < cfg_i.x_min) begin
      cls_d = whf_pkg::CLS_UNDER;
    end else if (req_i.sample >= cfg_i.x_max) begin
      cls_d = whf_pkg::CLS_OVER;
    end else begin
      cls_d = whf_pkg::CLS_BIN;
    end
  end

  assign s1_v_d = req_i.valid ? 1'b1 : (s2_go ? 1'b0 : s1_v_q);
  assign s2_v_d = s1_v_q ? 1'b1 : (q_ready_i ? 1'b0 : s2_v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_q <= s1_v_d;
      if (s2_go) s2_v_q <= s2_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && req_i.valid) begin
      s1_func_q <= whf_pkg::func_e'(req_i.func);
      s1_cls_q  <= cls_d;
      s1_diff_q <= whf_pkg::XW'(req_i.sample - cfg_i.x_min);
      s1_wgt_q  <= req_i.weight;
      s1_rs_q   <= req_i.read_slot;
    end
  end

  assign wsq_full = (2*whf_pkg::WGT_W)'(s1_wgt_q) * (2*whf_pkg::WGT_W)'(s1_wgt_q);

  always_ff @(posedge clk_i) begin
    if (s2_go && s1_v_q) begin
      s2_func_q <= s1_func_q;
      s2_cls_q  <= s1_cls_q;
      s2_prod_q <= (2*whf_pkg::XW)'(s1_diff_q) * (2*whf_pkg::XW)'(cfg_i.bin_scale);
      s2_wgt_q  <= s1_wgt_q;
      s2_wsq_q  <= wsq_full[whf_pkg::WSQ_W-1:0];
      s2_rs_q   <= s1_rs_q;
    end
  end

  assign idx = s2_prod_q[2*whf_pkg::XW-1:24];

  always_comb begin
    cmd_o.func     = s2_func_q;
    cmd_o.weight   = s2_wgt_q;
    cmd_o.wsq      = s2_wsq_q;
    cmd_o.in_range = 1'b1;
    cmd_o.slot     = s2_rs_q;
    if (s2_func_q == whf_pkg::FUNC_READ) begin
      cmd_o.in_range = ({1'b0, s2_rs_q} < (whf_pkg::SLOT_W + 1)'(whf_pkg::SLOTS));
    end else begin
      unique case (s2_cls_q)
        whf_pkg::CLS_UNDER: cmd_o.slot = whf_pkg::SLOT_W'(whf_pkg::NBINS);
        whf_pkg::CLS_OVER:  cmd_o.slot = whf_pkg::SLOT_W'(whf_pkg::NBINS + 1);
        default: begin
          if (idx > (2*whf_pkg::XW-24)'(whf_pkg::NBINS - 1)) begin
            cmd_o.slot = whf_pkg::SLOT_W'(whf_pkg::NBINS - 1);
          end else begin
            cmd_o.slot = idx[whf_pkg::SLOT_W-1:0];
          end
        end
      endcase
    end
  end

  assign push_o = s2_v_q;

endmodule

// File: rtl/whf_fifo.sv
module whf_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  whf_pkg::cmd_t    cmd_i,
  input  logic             pop_i,
  output whf_pkg::cmd_t    cmd_o,
  output whf_pkg::qstat_t  stat_o
);

  whf_pkg::cmd_t                 mem_q [whf_pkg::QDEPTH];
  logic [whf_pkg::QPTR_W-1:0]    wr_q, rd_q;
  logic [whf_pkg::QCNT_W-1:0]    cnt_q, cnt_d;
  logic                          do_push, do_pop;

  assign stat_o.full  = (cnt_q == whf_pkg::QCNT_W'(whf_pkg::QDEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= cmd_i;
  end

endmodule

// File: rtl/whf_back.sv
module whf_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  whf_pkg::cmd_t    cmd_i,
  input  whf_pkg::qstat_t  qstat_i,
  output logic             pop_o,
  whf_out_if.source        rsp_o
);

  whf_pkg::bk_state_e              state_q, state_d;
  whf_pkg::cmd_t                   cmd_q;
  whf_pkg::slot_t                  mem [whf_pkg::SLOTS];
  whf_pkg::slot_t                  rdata_q, cur, nxt;
  logic [whf_pkg::SLOTS-1:0]       vld_q;
  logic                            rvld_q;
  logic [whf_pkg::ADDR_W-1:0]      raddr, waddr;
  logic [whf_pkg::ENT_W-1:0]       ent_q;
  logic                            out_v_q;
  logic signed [whf_pkg::WT_W-1:0] out_wt_q;
  logic [whf_pkg::SQ_W-1:0]        out_sq_q;
  logic [whf_pkg::ENT_W-1:0]       out_ent_q;
  logic                            wr_en, ld_out, out_free;
  logic signed [whf_pkg::WT_W:0]   wsum_ext;
  logic [whf_pkg::SQ_W:0]          ssum_ext;

  assign raddr    = cmd_i.in_range ? cmd_i.slot[whf_pkg::ADDR_W-1:0] : '0;
  assign waddr    = cmd_q.slot[whf_pkg::ADDR_W-1:0];
  assign out_free = !out_v_q || rsp_o.ready;

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    wr_en   = 1'b0;
    ld_out  = 1'b0;
    unique case (state_q)
      whf_pkg::BK_IDLE: begin
        if (!qstat_i.empty) begin
          pop_o   = 1'b1;
          state_d = whf_pkg::BK_EXEC;
        end
      end
      whf_pkg::BK_EXEC: begin
        if (cmd_q.func == whf_pkg::FUNC_FILL) begin
          wr_en   = 1'b1;
          state_d = whf_pkg::BK_IDLE;
        end else if (out_free) begin
          ld_out  = 1'b1;
          state_d = whf_pkg::BK_IDLE;
        end
      end
      default: state_d = whf_pkg::BK_IDLE;
    endcase
  end

  // entries never written read as zero
  always_comb begin
    cur = '0;
    if (cmd_q.in_range && rvld_q) cur = rdata_q;
  end

  // saturating accumulate
  always_comb begin
    wsum_ext = {cur.wsum[whf_pkg::WT_W-1], cur.wsum}
             + (whf_pkg::WT_W + 1)'(cmd_q.weight);
    ssum_ext = {1'b0, cur.ssum} + (whf_pkg::SQ_W + 1)'(cmd_q.wsq);
    nxt.wsum = wsum_ext[whf_pkg::WT_W-1:0];
    if (wsum_ext[whf_pkg::WT_W] != wsum_ext[whf_pkg::WT_W-1]) begin
      nxt.wsum = wsum_ext[whf_pkg::WT_W]
               ? {1'b1, {(whf_pkg::WT_W-1){1'b0}}}
               : {1'b0, {(whf_pkg::WT_W-1){1'b1}}};
    end
    nxt.ssum = ssum_ext[whf_pkg::SQ_W] ? '1 : ssum_ext[whf_pkg::SQ_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= whf_pkg::BK_IDLE;
      vld_q   <= '0;
      ent_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (wr_en) begin
        vld_q[waddr] <= 1'b1;
        if (ent_q != '1) ent_q <= ent_q + 1'b1;
      end
      if (ld_out) begin
        out_v_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q   <= cmd_i;
      rdata_q <= mem[raddr];
      rvld_q  <= vld_q[raddr];
    end
    if (wr_en) mem[waddr] <= nxt;
    if (ld_out) begin
      out_wt_q  <= cur.wsum;
      out_sq_q  <= cur.ssum;
      out_ent_q <= ent_q;
    end
  end

  assign rsp_o.valid        = out_v_q;
  assign rsp_o.weight_total = out_wt_q;
  assign rsp_o.square_total = out_sq_q;
  assign rsp_o.entry_total  = out_ent_q;

endmodule

// File: rtl/weighted_histogram_fill_top.sv
// channel    dir  handshake      payload
// req_i      in   valid/ready    func, sample, weight, read_slot
// rsp_o      out  valid/ready    weight_total, square_total, entry_total
// cfg        in   cfg_we_i       cfg_idx_i, cfg_data_i
//
// front: classify at accept, then a registered 32x32 bin multiply, into a 2-entry queue
// back: per request, a slot memory read, then write-back or result load
// no new pop until the last request is written back or its result loaded
// a result passes s1, s2, the queue, the back's cmd_q and the output register
// reset clears per-slot valid bits and the entry count at once, no clearing pass
// a stalled result holds the back only on reads, the queue lets the front run ahead
module weighted_histogram_fill_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  whf_in_if.sink                        req_i,
  whf_out_if.source                     rsp_o,
  input  logic                          cfg_we_i,
  input  logic [whf_pkg::CIDX_W-1:0]    cfg_idx_i,
  input  logic [whf_pkg::CFG_W-1:0]     cfg_data_i
);

  whf_pkg::cfg_t   cfg_q;
  whf_pkg::cmd_t   push_cmd, pop_cmd;
  whf_pkg::qstat_t qstat;
  logic            push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_min     <= 32'sd0;
      cfg_q.x_max     <= 32'sd16777216;
      cfg_q.bin_scale <= 32'd65536;
    end else if (cfg_we_i) begin
      unique case (whf_pkg::cfg_idx_e'(cfg_idx_i))
        whf_pkg::CFG_X_MIN:     cfg_q.x_min     <= cfg_data_i;
        whf_pkg::CFG_X_MAX:     cfg_q.x_max     <= cfg_data_i;
        whf_pkg::CFG_BIN_SCALE: cfg_q.bin_scale <= cfg_data_i;
        default: ;
      endcase
    end
  end

  whf_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .req_i     (req_i),
    .push_o    (push),
    .cmd_o     (push_cmd),
    .q_ready_i (!qstat.full)
  );

  whf_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .cmd_o  (pop_cmd),
    .stat_o (qstat)
  );

  whf_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (pop_cmd),
    .qstat_i (qstat),
    .pop_o   (pop),
    .rsp_o   (rsp_o)
  );

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

  a_q_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(qstat.full && qstat.empty))
    else $error("queue full and empty");

  a_scale_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i == whf_pkg::CFG_BIN_SCALE)
    |=> cfg_q.bin_scale == $past(cfg_data_i))
    else $error("bin scale write lost");

  a_no_pop_while_push_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && qstat.full && !pop |=> push)
    else $error("queued request dropped");

endmodule
